// ===== hdl/keyframe_track_sampler_macros.svh =====
// ----------------------------------------------------------------------------
// keyframe_track_sampler_macros
// assertion macros for the keyframe track sampler
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_TRACK_SAMPLER_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_MACROS_SVH

// clocked check, off while reset is held
`define KTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define KTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg
// shared constants and types of the keyframe track sampler
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

  // track storage
  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int KCNT_W   = 7;

  // field widths
  localparam int TIME_W  = 32;
  localparam int COMP_W  = 32;
  localparam int FRAC_W  = 17;
  localparam int WHERE_W = 2;

  // stream widths
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 96;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_KEY_COUNT = 1'b0;
  localparam logic [KCNT_W-1:0] KEY_COUNT_RESET = 7'd1;

  // item kinds on tuser
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // result classification
  localparam logic [WHERE_W-1:0] WHERE_INTERP = 2'd0;
  localparam logic [WHERE_W-1:0] WHERE_FIRST  = 2'd1;
  localparam logic [WHERE_W-1:0] WHERE_LAST   = 2'd2;

  // one stored key vector, x in the low bits
  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
  } vec3_t;

  localparam int VEC_W = $bits(vec3_t);

endpackage

`default_nettype wire

// ===== hdl/kts_ram.sv =====
// ----------------------------------------------------------------------------
// kts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module kts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/kts_div.sv =====
// ----------------------------------------------------------------------------
// kts_div
// restoring divider for the q1.16 fraction num * 65536 / den, num <= den
// ----------------------------------------------------------------------------
`default_nettype none

module kts_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [kts_pkg::TIME_W-1:0]    num,
  input  wire logic [kts_pkg::TIME_W-1:0]    den,
  output      logic                          busy,
  output      logic [kts_pkg::FRAC_W-1:0]    quo
);

  localparam int TW = kts_pkg::TIME_W;
  localparam int FW = kts_pkg::FRAC_W;
  localparam int CW = $clog2(FW);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] den_r, den_nxt;
  logic [FW-1:0] quo_r, quo_nxt;

  logic [TW:0]   trial;
  logic          fits;
  logic          whole;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, 1'b0};
    fits     = (trial >= {1'b0, den_r});
    whole    = (num >= den);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(FW - 1);
      den_nxt  = den;
      rem_nxt  = whole ? (num - den) : num;
      quo_nxt  = {whole, {(FW-1){1'b0}}};
    end else if (busy_r) begin
      rem_nxt  = fits ? TW'(trial - {1'b0, den_r}) : trial[TW-1:0];
      quo_nxt  = {quo_r[FW-1], quo_r[FW-3:0], fits};
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== hdl/kts_lerp.sv =====
// ----------------------------------------------------------------------------
// kts_lerp
// one component of the interpolation: a + floor((b - a) * f / 65536), saturated
// ----------------------------------------------------------------------------
`default_nettype none

module kts_lerp (
  input  wire logic                              clk,
  input  wire logic                              mul_en,
  input  wire logic signed [kts_pkg::COMP_W-1:0] a,
  input  wire logic signed [kts_pkg::COMP_W-1:0] b,
  input  wire logic [kts_pkg::FRAC_W-1:0]        frac,
  output      logic signed [kts_pkg::COMP_W-1:0] res
);

  localparam int CW = kts_pkg::COMP_W;
  localparam int DW = CW + 1;
  localparam int PW = DW + kts_pkg::FRAC_W + 1;
  localparam int SW = PW - 16;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_nxt, prod_r;
  logic signed [SW-1:0] part;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] max_v, min_v;

  // difference and product, registered before the add
  always_comb begin
    diff     = DW'(b) - DW'(a);
    prod_nxt = PW'(diff) * PW'($signed({1'b0, frac}));
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // floor shift, add and clamp to the signed range
  always_comb begin
    part  = prod_r[PW-1:16];
    sum   = SW'(a) + part;
    max_v = SW'({1'b0, {(CW-1){1'b1}}});
    min_v = -max_v - SW'(1);
    priority if (sum > max_v) begin
      res = max_v[CW-1:0];
    end else if (sum < min_v) begin
      res = min_v[CW-1:0];
    end else begin
      res = sum[CW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/keyframe_track_sampler.sv =====
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// piecewise linear keyframe track: key writes and time samples over a stream
// ----------------------------------------------------------------------------
// a sample scans one stored key per cycle from the time memory, then reads the
//   bracketing key vectors and, when interpolating over a nonzero interval, waits
//   for the fraction divider before the multiply
// throughput: one item in flight; the next is taken once the result is loaded
// reset: synchronous active-low, key_count returns to 1, key memories are not
//   cleared and hold unknown data until written
`default_nettype none

`include "keyframe_track_sampler_macros.svh"

module keyframe_track_sampler (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // slave stream
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // key_slot[5:0] key_time[37:6] key_x[69:38] key_y[101:70] key_z[133:102]
  // sample_time[165:134], zero pad
  input  wire logic [kts_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[0]
  input  wire logic                               in_tuser,
  // master stream
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // out_x[31:0] out_y[63:32] out_z[95:64]
  output      logic [kts_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // where_found[1:0]
  output      logic [kts_pkg::WHERE_W-1:0]        out_tuser,
  // configuration port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [kts_pkg::CFG_AW-1:0]         cfg_paddr,
  input  wire logic [kts_pkg::CFG_DW-1:0]         cfg_pwdata,
  output      logic [kts_pkg::CFG_DW-1:0]         cfg_prdata,
  output      logic                               cfg_pready
);

  localparam int AW = kts_pkg::KEY_AW;
  localparam int NW = kts_pkg::KCNT_W;
  localparam int TW = kts_pkg::TIME_W;
  localparam int FW = kts_pkg::FRAC_W;
  localparam int WW = kts_pkg::WHERE_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_RDA  = 8'b0000_0100,
    ST_RDB  = 8'b0000_1000,
    ST_CAPB = 8'b0001_0000,
    ST_WDIV = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration register
  logic [NW-1:0]  key_count_r;
  logic           cfg_wr;

  // input unpacking
  logic [AW-1:0]        in_slot;
  logic [TW-1:0]        in_key_time;
  kts_pkg::vec3_t       in_vec;
  logic [TW-1:0]        in_sample;
  logic                 in_acc;
  logic                 key_we;

  // scan state
  logic [TW-1:0]  s_r, s_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic [NW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [NW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [TW-1:0]  prev_t_r, prev_t_nxt;
  logic [TW-1:0]  t0_r, t0_nxt;
  logic [AW-1:0]  va_idx_r, va_idx_nxt;
  logic [AW-1:0]  vb_idx_r, vb_idx_nxt;
  logic           direct_r, direct_nxt;
  logic [WW-1:0]  where_r, where_nxt;
  kts_pkg::vec3_t va_r, va_nxt;
  kts_pkg::vec3_t vb_r, vb_nxt;

  // memories
  logic [AW-1:0]         t_raddr;
  logic [TW-1:0]         t_rdata;
  logic [AW-1:0]         v_raddr;
  logic [kts_pkg::VEC_W-1:0] v_rdata;

  // scan compare
  logic [TW-1:0]  cur_t;
  logic [TW-1:0]  first_t;
  logic [TW-1:0]  span;
  logic           bracket;
  logic           last_pair;
  logic [NW-1:0]  n_clamp;

  // divider and interpolation
  logic           div_start;
  logic           div_busy;
  logic [FW-1:0]  frac;
  logic           mul_en;
  kts_pkg::vec3_t lerp_res;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic [kts_pkg::OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic [WW-1:0]                     out_user_r, out_user_nxt;
  logic                              out_load;

  // configuration write and read back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == kts_pkg::REG_KEY_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == kts_pkg::REG_KEY_COUNT) ?
                      kts_pkg::CFG_DW'(key_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= kts_pkg::KEY_COUNT_RESET;
    end else if (cfg_wr) begin
      key_count_r <= cfg_pwdata[NW-1:0];
    end
  end

  // input fields
  assign in_slot     = in_tdata[AW-1:0];
  assign in_key_time = in_tdata[37:6];
  assign in_vec      = in_tdata[133:38];
  assign in_sample   = in_tdata[165:134];
  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign key_we      = in_acc && (in_tuser == kts_pkg::FUNC_WRITE);

  // effective key count
  always_comb begin
    priority if (key_count_r == '0) begin
      n_clamp = NW'(1);
    end else if (key_count_r > NW'(kts_pkg::MAX_KEYS)) begin
      n_clamp = NW'(kts_pkg::MAX_KEYS);
    end else begin
      n_clamp = key_count_r;
    end
  end

  // key times and key vectors
  kts_ram #(.WIDTH(TW), .DEPTH(kts_pkg::MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_slot),
    .wdata (in_key_time),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kts_ram #(.WIDTH(kts_pkg::VEC_W), .DEPTH(kts_pkg::MAX_KEYS)) u_vec_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_slot),
    .wdata (in_vec),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  assign t_raddr = (state_r == ST_IDLE) ? '0 : rd_idx_r[AW-1:0];
  assign v_raddr = (state_r == ST_RDB) ? vb_idx_r : va_idx_r;

  // pair compare on the time just read
  always_comb begin
    cur_t     = t_rdata;
    first_t   = (cmp_idx_r == '0) ? cur_t : t0_r;
    bracket   = (cmp_idx_r != '0) && (prev_t_r <= s_r) && (s_r <= cur_t);
    last_pair = (cmp_idx_r == (n_r - NW'(1)));
    span      = cur_t - prev_t_r;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    s_nxt       = s_r;
    n_nxt       = n_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    prev_t_nxt  = prev_t_r;
    t0_nxt      = t0_r;
    va_idx_nxt  = va_idx_r;
    vb_idx_nxt  = vb_idx_r;
    direct_nxt  = direct_r;
    where_nxt   = where_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    div_start   = 1'b0;
    mul_en      = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == kts_pkg::FUNC_SAMPLE)) begin
          s_nxt       = in_sample;
          n_nxt       = n_clamp;
          cmp_idx_nxt = '0;
          rd_idx_nxt  = NW'(1);
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        prev_t_nxt  = cur_t;
        t0_nxt      = first_t;
        cmp_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + NW'(1);
        priority if (bracket) begin
          va_idx_nxt = AW'(cmp_idx_r - NW'(1));
          vb_idx_nxt = cmp_idx_r[AW-1:0];
          where_nxt  = kts_pkg::WHERE_INTERP;
          direct_nxt = (span == '0);
          div_start  = (span != '0);
          state_nxt  = ST_RDA;
        end else if (last_pair) begin
          direct_nxt = 1'b1;
          priority if (s_r < first_t) begin
            va_idx_nxt = '0;
            where_nxt  = kts_pkg::WHERE_FIRST;
          end else if ((n_r == NW'(1)) && (s_r == first_t)) begin
            va_idx_nxt = '0;
            where_nxt  = kts_pkg::WHERE_INTERP;
          end else begin
            va_idx_nxt = AW'(n_r - NW'(1));
            where_nxt  = kts_pkg::WHERE_LAST;
          end
          state_nxt = ST_RDA;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_RDA: begin
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        va_nxt    = v_rdata;
        state_nxt = ST_CAPB;
      end
      ST_CAPB: begin
        vb_nxt    = v_rdata;
        state_nxt = direct_r ? ST_FIN : ST_WDIV;
      end
      ST_WDIV: begin
        if (!div_busy) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample working registers
  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    n_r       <= n_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    prev_t_r  <= prev_t_nxt;
    t0_r      <= t0_nxt;
    va_idx_r  <= va_idx_nxt;
    vb_idx_r  <= vb_idx_nxt;
    direct_r  <= direct_nxt;
    where_r   <= where_nxt;
    va_r      <= va_nxt;
    vb_r      <= vb_nxt;
  end

  // fraction of the bracketing interval
  kts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (s_r - prev_t_r),
    .den   (span),
    .busy  (div_busy),
    .quo   (frac)
  );

  // per-component interpolation
  kts_lerp u_lerp_x (
    .clk (clk), .mul_en (mul_en), .a (va_r.x), .b (vb_r.x), .frac (frac), .res (lerp_res.x)
  );

  kts_lerp u_lerp_y (
    .clk (clk), .mul_en (mul_en), .a (va_r.y), .b (vb_r.y), .frac (frac), .res (lerp_res.y)
  );

  kts_lerp u_lerp_z (
    .clk (clk), .mul_en (mul_en), .a (va_r.z), .b (vb_r.z), .frac (frac), .res (lerp_res.z)
  );

  // output register, loaded while the previous transaction drains
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = direct_r ? va_r : lerp_res;
      out_user_nxt  = where_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  `KTS_ASSERT(a_rdy_div_idle, in_tready |-> !div_busy, "input taken while divider busy")
  `KTS_ASSERT(a_load_from_fin, $rose(out_valid_r) |-> $past(state_r == ST_FIN), "result not from final step")
  `KTS_ASSERT(a_scan_in_range, (state_r == ST_SCAN) |-> (cmp_idx_r < n_r), "scan past last key")
  `KTS_ASSERT(a_mul_after_div, (state_r == ST_MUL) |-> (!div_busy && !direct_r), "multiply before fraction ready")

endmodule

`default_nettype wire

// ===== sim/keyframe_track_sampler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_track_sampler_tb
// loads keyframe tracks over the input stream and samples them at chosen times
// the result stream is checked field by field against an interpolating
// predictor that mirrors the key store and key_count
// ----------------------------------------------------------------------------

module keyframe_track_sampler_tb;
  import kts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TARGET_ITEMS   = 1350;
  localparam int REPORT_CAP     = 50;
  localparam logic [CFG_AW-1:0] KEY_COUNT_ADDR = CFG_AW'(4 * REG_KEY_COUNT);

  // one expected sample transaction
  typedef struct packed {
    vec3_t                v;
    logic [WHERE_W-1:0]   where;
  } sample_t;

  // --------------------------------------------------------------------------
  // track predictor and result store
  // --------------------------------------------------------------------------
  class track_scoreboard;
    bit [TIME_W-1:0] key_times [MAX_KEYS];
    vec3_t           key_vecs [MAX_KEYS];
    bit [KCNT_W-1:0] key_count;
    sample_t         pending_q [$];
    int              errors;

    function new();
      key_count = KEY_COUNT_RESET;
      errors    = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // v1 + floor((v2 - v1) * f / 65536), saturated
    function int blend_component(int a, int b, int unsigned frac);
      longint prod;
      longint sum;
      prod = (longint'(b) - longint'(a)) * longint'(frac);
      sum  = longint'(a) + (prod >>> 16);
      if (sum > 64'sh0000_0000_7FFF_FFFF) sum = 64'sh0000_0000_7FFF_FFFF;
      if (sum < -64'sh0000_0000_8000_0000) sum = -64'sh0000_0000_8000_0000;
      return int'(sum);
    endfunction

    function sample_t sample_track(bit [TIME_W-1:0] st);
      int unsigned     n;
      int unsigned     i;
      int unsigned     frac;
      bit [TIME_W-1:0] t1;
      bit [TIME_W-1:0] t2;
      bit [TIME_W-1:0] span;
      sample_t         r;
      n = key_count;
      if (n < 1) n = 1;
      if (n > MAX_KEYS) n = MAX_KEYS;
      // first bracketing pair wins
      for (i = 0; i + 1 < n; i++) begin
        t1 = key_times[i];
        t2 = key_times[i+1];
        if (t1 <= st && st <= t2) begin
          span = t2 - t1;
          r.where = WHERE_INTERP;
          if (span == 0) begin
            r.v = key_vecs[i];
            return r;
          end
          frac = 32'((64'(st - t1) << 16) / 64'(span));
          r.v.x = blend_component(key_vecs[i].x, key_vecs[i+1].x, frac);
          r.v.y = blend_component(key_vecs[i].y, key_vecs[i+1].y, frac);
          r.v.z = blend_component(key_vecs[i].z, key_vecs[i+1].z, frac);
          return r;
        end
      end
      // no bracket: clamp
      if (st < key_times[0]) begin
        r.v = key_vecs[0];
        r.where = WHERE_FIRST;
      end else if (n == 1 && st == key_times[0]) begin
        r.v = key_vecs[0];
        r.where = WHERE_INTERP;
      end else begin
        r.v = key_vecs[n-1];
        r.where = WHERE_LAST;
      end
      return r;
    endfunction

    function void note_item(logic func, logic [IN_TDATA_W-1:0] d);
      bit [KEY_AW-1:0] slot;
      if (func == FUNC_WRITE) begin
        slot = d[5:0];
        key_times[slot] = d[37:6];
        key_vecs[slot]  = d[133:38];
      end else begin
        pending_q.insert(pending_q.size(), sample_track(d[165:134]));
      end
    endfunction

    function void report(string what, logic [31:0] exp_val, logic [31:0] got_val);
      if (errors < REPORT_CAP)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_val, got_val);
      errors++;
    endfunction

    function void check_sample(logic [OUT_TDATA_W-1:0] d, logic [WHERE_W-1:0] where);
      sample_t e;
      vec3_t   got;
      got = d;
      if (pending_q.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t: unexpected result: expected none, actual x=%h y=%h z=%h where=%0d",
                   $time, got.x, got.y, got.z, where);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.x !== e.v.x) report("out_x", e.v.x, got.x);
      if (got.y !== e.v.y) report("out_y", e.v.y, got.y);
      if (got.z !== e.v.z) report("out_z", e.v.z, got.z);
      if (where !== e.where) report("where_found", 32'(e.where), 32'(where));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [WHERE_W-1:0]     out_tuser;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  track_scoreboard sb;
  bit [TIME_W-1:0] track_time [MAX_KEYS];
  bit              steady_sender;
  int              items_sent;
  int              quiet_cycles;
  int              ready_hold;

  keyframe_track_sampler u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // result-side backpressure: runs of ready, short stalls, a few long ones
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_tready = 1'b1;
          ready_hold = $urandom_range(0, 30);
        end
        9: begin
          out_tready = 1'b0;
          ready_hold = $urandom_range(10, 60);
        end
        default: begin
          out_tready = 1'b0;
          ready_hold = $urandom_range(0, 3);
        end
      endcase
    end
  end

  // monitor: transactions on all ports, plus the stall watchdog
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_item(in_tuser, in_tdata);
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        sb.check_sample(out_tdata, out_tuser);
        moved = 1'b1;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == KEY_COUNT_ADDR) begin
        sb.key_count = cfg_pwdata[KCNT_W-1:0];
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [31:0] rand_component();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r < 4) return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    return $urandom;
  endfunction

  function automatic int eff_keys(bit [KCNT_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_KEYS) return MAX_KEYS;
    return v;
  endfunction

  // one input transaction, after a random gap
  task automatic send_item(input logic func, input logic [IN_TDATA_W-1:0] data);
    int gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_key(input int slot, input bit [31:0] t,
                           input bit [31:0] x, input bit [31:0] y, input bit [31:0] z);
    track_time[slot] = t;
    send_item(FUNC_WRITE, IN_TDATA_W'({32'h0, z, y, x, t, 6'(slot)}));
  endtask

  task automatic sample_at(input bit [31:0] t);
    send_item(FUNC_SAMPLE, IN_TDATA_W'({t, 96'h0, $urandom, 6'($urandom)}));
  endtask

  // hold the sender until every result is back, then let writes settle
  task automatic wait_drained(input int extra);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // apb write: setup then access phase
  task automatic write_key_count(input bit [KCNT_W-1:0] v);
    wait_drained(16);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = KEY_COUNT_ADDR;
    cfg_pwdata  = CFG_DW'(v);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // mostly ascending track with repeats, a few drops, several spacing scales
  task automatic load_track(input int n);
    bit [63:0]   t;
    int unsigned step_max;
    int          i;
    int          r;
    case ($urandom_range(0, 3))
      0:       step_max = 16;
      1:       step_max = 32'h0001_0000;
      2:       step_max = 32'h0400_0000;
      default: step_max = 32'hFFFF_FFFF / n;
    endcase
    t = ($urandom_range(0, 1) == 0) ? 64'h0 : 64'($urandom_range(0, 32'h0010_0000));
    for (i = 0; i < n; i++) begin
      if (i == n - 1 && $urandom_range(0, 4) == 0) t = 64'hFFFF_FFFF;
      write_key(i, t[31:0], rand_component(), rand_component(), rand_component());
      r = $urandom_range(0, 99);
      if (r < 8)
        t = t;
      else if (r < 12)
        t = 64'($urandom_range(t[31:0], 0));
      else
        t = t + 64'($urandom_range(step_max, 1));
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    end
  endtask

  function automatic bit [31:0] pick_sample_time(input int n);
    int        i;
    bit [31:0] lo;
    bit [31:0] hi;
    case ($urandom_range(0, 7))
      0: return track_time[$urandom_range(0, n - 1)];
      1, 2, 3: begin
        if (n < 2) return $urandom;
        i  = $urandom_range(0, n - 2);
        lo = track_time[i];
        hi = track_time[i+1];
        return (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
      end
      4: return (track_time[0] != 0) ? $urandom_range(track_time[0] - 1, 0) : 32'h0;
      5: begin
        lo = track_time[n-1];
        return (lo != 32'hFFFF_FFFF) ? $urandom_range(32'hFFFF_FFFF, lo + 1) : lo;
      end
      6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bit [KCNT_W-1:0] corner_counts [6];
    bit [KCNT_W-1:0] kc;
    int              n;
    int              k;
    int              samples;

    corner_counts = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = FUNC_WRITE;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    ready_hold  = 0;
    items_sent  = 0;
    quiet_cycles = 0;
    steady_sender = 1'b0;
    sb = new();

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // single key at reset count: before, exact match, after
    write_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    sample_at(32'h0);
    sample_at(32'h0001_0000);
    sample_at(32'hFFFF_FFFF);

    // zero interval at the head, full-scale swings, last key at max time
    write_key_count(7'd4);
    write_key(0, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5);
    write_key(1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFB);
    write_key(2, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h3);
    write_key(3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    sample_at(32'h0002_0000);
    sample_at(32'h0002_8000);
    sample_at(32'h0003_0000);
    sample_at(32'h8000_0000);
    sample_at(32'hFFFF_FFFF);
    sample_at(32'h0001_FFFF);

    // key count of zero behaves as one
    write_key_count(7'd0);
    sample_at(32'h0002_0000);

    // out-of-order times leave a gap that clamps to the last key
    write_key_count(7'd3);
    write_key(0, 32'h0001_0000, 32'h1, 32'h2, 32'h3);
    write_key(1, 32'h0009_0000, 32'h0010_0000, 32'hFFF0_0000, 32'h0);
    write_key(2, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0, 32'h1);
    sample_at(32'h000A_0000);
    sample_at(32'h0005_0000);

    // random tracks under several key counts
    while (items_sent < TARGET_ITEMS) begin
      k = $urandom_range(0, 9);
      if (k < 2)
        kc = corner_counts[$urandom_range(0, 5)];
      else if (k < 8)
        kc = 7'($urandom_range(1, 8));
      else
        kc = 7'($urandom_range(9, 64));
      write_key_count(kc);
      n = eff_keys(kc);
      steady_sender = ($urandom_range(0, 3) == 0);
      load_track(n);
      samples = $urandom_range(15, 50);
      repeat (samples) begin
        k = $urandom_range(0, 99);
        if (k < 6)
          write_key($urandom_range(0, MAX_KEYS - 1), $urandom,
                    rand_component(), rand_component(), rand_component());
        else if (k < 8)
          wait_drained(0);
        else
          sample_at(pick_sample_time(n));
      end
    end

    wait_drained(100);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
